// ===== rtl/sast_pkg.sv =====
// ----------------------------------------------------------------------------
// sast_pkg - shared constants, types and tables for the slime agent step
// Map geometry, fixed-point formats, sine step table, microcode ROM.
// ----------------------------------------------------------------------------
package sast_pkg;

	// map and number formats
	localparam int MAP_WIDTH    = 256;
	localparam int MAP_HEIGHT   = 256;
	localparam int FRAC_BITS    = 8;
	localparam int HEADING_BITS = 10;
	localparam int POS_W        = 16;
	localparam int ANGLE_W      = 9;
	localparam int PIX_W        = 8;
	localparam int OUT_W        = 8;

	localparam int QBITS   = HEADING_BITS - 2;
	localparam int QSTEPS  = 1 << QBITS;
	localparam int MAG_W   = FRAC_BITS + 1;
	localparam int STEP_W  = FRAC_BITS + 2;
	localparam int SUM_W   = POS_W + 2;
	localparam int XCELL_W = $clog2(MAP_WIDTH);
	localparam int YCELL_W = $clog2(MAP_HEIGHT);
	localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int ADDR_W  = $clog2(MAP_DEPTH);

	localparam logic [PIX_W-1:0] TRAIL_FULL = PIX_W'(255);
	localparam logic [PIX_W-1:0] TRAIL_ZERO = '0;
	localparam logic [ANGLE_W-1:0] ANGLE_RESET = ANGLE_W'(128);

	localparam logic signed [SUM_W-1:0] X_TOP = SUM_W'(MAP_WIDTH * (2 ** FRAC_BITS));
	localparam logic signed [SUM_W-1:0] Y_TOP = SUM_W'(MAP_HEIGHT * (2 ** FRAC_BITS));
	localparam logic [POS_W-1:0] X_LAST = POS_W'((MAP_WIDTH - 1) * (2 ** FRAC_BITS));
	localparam logic [POS_W-1:0] Y_LAST = POS_W'((MAP_HEIGHT - 1) * (2 ** FRAC_BITS));

	// sine polynomial constants, Q15
	localparam longint SIN_A = 51472;
	localparam longint SIN_B = 21024;
	localparam longint SIN_C = 2320;

	// register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ANGLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_ANGLE   = 1'd1;

	// actions
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_PLACE = 2'd1;
	localparam logic [1:0] ACT_STEP  = 2'd2;

	// move kinds
	localparam logic [1:0] KIND_FORWARD = 2'd0;
	localparam logic [1:0] KIND_RIGHT   = 2'd1;
	localparam logic [1:0] KIND_LEFT    = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	// program counter values
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
	localparam logic [PC_W-1:0] PC_WRPIX   = 4'd1;
	localparam logic [PC_W-1:0] PC_PLACE   = 4'd2;
	localparam logic [PC_W-1:0] PC_NOSTEP  = 4'd3;
	localparam logic [PC_W-1:0] PC_SENSE_C = 4'd4;
	localparam logic [PC_W-1:0] PC_SENSE_L = 4'd5;
	localparam logic [PC_W-1:0] PC_SENSE_R = 4'd6;
	localparam logic [PC_W-1:0] PC_DECIDE  = 4'd7;
	localparam logic [PC_W-1:0] PC_MOVE    = 4'd8;

	// control word field codes
	localparam logic [1:0] HSEL_C = 2'd0;
	localparam logic [1:0] HSEL_L = 2'd1;
	localparam logic [1:0] HSEL_R = 2'd2;

	localparam logic [1:0] CAP_NONE = 2'd0;
	localparam logic [1:0] CAP_C    = 2'd1;
	localparam logic [1:0] CAP_L    = 2'd2;

	localparam logic [1:0] JMP_NEXT   = 2'd0;
	localparam logic [1:0] JMP_IDLE   = 2'd1;
	localparam logic [1:0] JMP_ACCEPT = 2'd2;

	typedef struct packed {
		logic [1:0] hsel;     // heading used for the sensor address
		logic       sense;    // issue a sensor read
		logic [1:0] cap;      // which sample to capture from read data
		logic       wr_pixel; // write request pixel
		logic       place;    // load agent from request
		logic       decide;   // compare samples, pick heading
		logic       move;     // move, clamp, mark trail
		logic       emit;     // load output register (waits for a free slot)
		logic [1:0] jmp;
	} ctl_t;

	function automatic ctl_t ucode(logic [PC_W-1:0] pc);
		ctl_t c;
		c = '{hsel: HSEL_C, sense: 1'b0, cap: CAP_NONE, wr_pixel: 1'b0, place: 1'b0,
			decide: 1'b0, move: 1'b0, emit: 1'b0, jmp: JMP_NEXT};
		case (pc)
			PC_IDLE: begin
				c.jmp = JMP_ACCEPT;
			end
			PC_WRPIX: begin
				c.wr_pixel = 1'b1;
				c.emit = 1'b1;
				c.jmp = JMP_IDLE;
			end
			PC_PLACE: begin
				c.place = 1'b1;
				c.emit = 1'b1;
				c.jmp = JMP_IDLE;
			end
			PC_NOSTEP: begin
				c.emit = 1'b1;
				c.jmp = JMP_IDLE;
			end
			PC_SENSE_C: begin
				c.hsel = HSEL_C;
				c.sense = 1'b1;
			end
			PC_SENSE_L: begin
				c.hsel = HSEL_L;
				c.sense = 1'b1;
				c.cap = CAP_C;
			end
			PC_SENSE_R: begin
				c.hsel = HSEL_R;
				c.sense = 1'b1;
				c.cap = CAP_L;
			end
			PC_DECIDE: begin
				c.decide = 1'b1;
			end
			PC_MOVE: begin
				c.move = 1'b1;
				c.emit = 1'b1;
				c.jmp = JMP_IDLE;
			end
			default: begin
				c.jmp = JMP_IDLE;
			end
		endcase
		return c;
	endfunction

	function automatic logic [PC_W-1:0] entry_pc(logic [1:0] action);
		logic [PC_W-1:0] pc;
		case (action)
			ACT_WRITE: pc = PC_WRPIX;
			ACT_PLACE: pc = PC_PLACE;
			ACT_STEP:  pc = PC_SENSE_C;
			default:   pc = PC_NOSTEP;
		endcase
		return pc;
	endfunction

	// quarter-turn sine in Q14, scaled to a rounded step in FRAC_BITS
	function automatic longint quarter_mag(int r);
		longint t, t2, inner, mid, qs;
		t = longint'(r) << (14 - QBITS);
		t2 = (t * t) >> 14;
		inner = SIN_B - ((t2 * SIN_C) >> 14);
		mid = SIN_A - ((t2 * inner) >> 14);
		qs = (t * mid) >> 15;
		return ((qs << FRAC_BITS) + 8192) >> 14;
	endfunction

	typedef logic [MAG_W-1:0] mag_tab_t [QSTEPS];

	function automatic mag_tab_t build_mag_tab();
		mag_tab_t tab;
		for (int r = 0; r < QSTEPS; r++) begin
			tab[r] = MAG_W'(quarter_mag(r));
		end
		return tab;
	endfunction

	localparam mag_tab_t MAG_TAB = build_mag_tab();
	localparam logic [MAG_W-1:0] MAG_FULL = MAG_W'(quarter_mag(QSTEPS));

	// signed one-pixel step along sine of heading h
	function automatic logic signed [STEP_W-1:0] unit_step(logic [HEADING_BITS-1:0] h);
		logic [1:0]       q;
		logic [QBITS:0]   r;
		logic [MAG_W-1:0] mag;
		logic signed [STEP_W-1:0] m;
		q = h[HEADING_BITS-1 -: 2];
		r = {1'b0, h[QBITS-1:0]};
		if (q[0]) begin
			r = (QBITS+1)'(QSTEPS) - r;
		end
		mag = r[QBITS] ? MAG_FULL : MAG_TAB[r[QBITS-1:0]];
		m = $signed({1'b0, mag});
		return q[1] ? -m : m;
	endfunction

endpackage

// ===== rtl/slime_agent_sense_turn_step.sv =====
// ----------------------------------------------------------------------------
// slime_agent_sense_turn_step - one slime agent sensing and moving on a trail map
// Microcoded sequencer over a single-port 8-bit trail map: write pixel,
// place agent, or sense three cells ahead, turn, move, clamp, mark trail.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in       request    in_valid / in_ready    action, pixel_*, place_*, random_heading
//  out      result     out_valid / out_ready  agent_column, agent_row, move_kind, hit_wall
//  cfg      write      cfg_we                 cfg_index, cfg_data
//
// A step request runs idle/accept, three sensor reads, decide and move in
// turn; write, place and unused actions run idle/accept and one action row,
// as the one port of the trail map takes three reads and the trail write in
// turn. After reset the map is cleared one cell a cycle over all 65536 cells
// with in_ready low; configuration writes are taken throughout.
// A finished result sits in the output register; the next request is taken
// meanwhile, and only a second result waits until the first one is taken.
//
module slime_agent_sense_turn_step (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic [7:0]  pixel_value,
	input  logic [15:0] place_x,
	input  logic [15:0] place_y,
	input  logic [9:0]  place_heading,
	input  logic [9:0]  random_heading,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  agent_column,
	output logic [7:0]  agent_row,
	output logic [1:0]  move_kind,
	output logic        hit_wall,

	input  logic        cfg_we,
	input  logic [sast_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sast_pkg::ANGLE_W-1:0]   cfg_data
);

	localparam int HB = sast_pkg::HEADING_BITS;
	localparam int FB = sast_pkg::FRAC_BITS;
	localparam int SW = sast_pkg::SUM_W;
	localparam int AW = sast_pkg::ADDR_W;
	localparam int PW = sast_pkg::POS_W;

	// ---------------- sequencer ----------------
	logic [sast_pkg::PC_W-1:0] pc_q;
	sast_pkg::ctl_t            ctl;
	logic                      go;       // row executes this cycle
	logic                      accept;

	// ---------------- map clear ----------------
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	// ---------------- configuration ----------------
	logic [sast_pkg::ANGLE_W-1:0] sensor_angle_q;
	logic [sast_pkg::ANGLE_W-1:0] turn_angle_q;

	// ---------------- latched request ----------------
	logic [7:0]    pixel_x_q, pixel_y_q, pixel_value_q;
	logic [PW-1:0] place_x_q, place_y_q;
	logic [HB-1:0] place_heading_q, random_heading_q;

	// ---------------- agent state ----------------
	logic [PW-1:0] agent_x_q, agent_y_q;
	logic [HB-1:0] heading_q;

	// ---------------- step datapath ----------------
	logic [7:0]    centre_q, left_q;
	logic          ok_s1;     // last sensor read was inside the map
	logic [HB-1:0] h_new_q;
	logic [1:0]    kind_q;

	logic [HB-1:0] sense_h;
	logic signed [SW-1:0] sx, sy;
	logic          sense_ok;
	logic [AW-1:0] sense_addr;
	logic [7:0]    right_val;

	logic signed [SW-1:0] nx, ny;
	logic [PW-1:0] move_x, move_y;
	logic          move_wall;
	logic [AW-1:0] move_addr;

	logic          pixel_ok;
	logic [AW-1:0] pixel_addr;

	logic [PW-1:0] agent_x_nxt, agent_y_nxt;

	// ---------------- map port ----------------
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata, ram_rdata;

	// ---------------- output register ----------------
	logic       out_valid_q;
	logic [7:0] agent_column_q, agent_row_q;
	logic [1:0] move_kind_q;
	logic       hit_wall_q;

	assign ctl      = sast_pkg::ucode(pc_q);
	assign in_ready = (pc_q == sast_pkg::PC_IDLE) && !clearing_q;
	assign accept   = in_valid && in_ready;
	// a result row holds until the output register has room
	assign go       = !(ctl.emit && out_valid_q && !out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= sast_pkg::PC_IDLE;
		end else begin
			case (ctl.jmp)
				sast_pkg::JMP_ACCEPT: begin
					if (accept) begin
						pc_q <= sast_pkg::entry_pc(action);
					end
				end
				sast_pkg::JMP_IDLE: begin
					if (go) begin
						pc_q <= sast_pkg::PC_IDLE;
					end
				end
				default: begin
					pc_q <= pc_q + sast_pkg::PC_W'(1);
				end
			endcase
		end
	end

	// clearing pass over the whole map after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == {AW{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_angle_q <= sast_pkg::ANGLE_RESET;
			turn_angle_q   <= sast_pkg::ANGLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sast_pkg::REG_SENSOR_ANGLE: sensor_angle_q <= cfg_data;
				sast_pkg::REG_TURN_ANGLE:   turn_angle_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_x_q        <= pixel_x;
			pixel_y_q        <= pixel_y;
			pixel_value_q    <= pixel_value;
			place_x_q        <= place_x;
			place_y_q        <= place_y;
			place_heading_q  <= place_heading;
			random_heading_q <= random_heading;
		end
	end

	// sensor address: one pixel ahead along the selected heading
	always_comb begin
		case (ctl.hsel)
			sast_pkg::HSEL_L: sense_h = heading_q - HB'(sensor_angle_q);
			sast_pkg::HSEL_R: sense_h = heading_q + HB'(sensor_angle_q);
			default:          sense_h = heading_q;
		endcase
		sx = $signed({2'b00, agent_x_q})
			+ SW'(sast_pkg::unit_step(sense_h + HB'(sast_pkg::QSTEPS)));
		sy = $signed({2'b00, agent_y_q}) + SW'(sast_pkg::unit_step(sense_h));
		// floor below zero or cell beyond the edge reads as empty
		sense_ok = !sx[SW-1] && !sy[SW-1] && (sx < sast_pkg::X_TOP) && (sy < sast_pkg::Y_TOP);
		sense_addr = AW'(32'(sy[FB +: sast_pkg::YCELL_W]) * sast_pkg::MAP_WIDTH
			+ 32'(sx[FB +: sast_pkg::XCELL_W]));
	end

	assign right_val = ok_s1 ? ram_rdata : sast_pkg::TRAIL_ZERO;

	// move along the chosen heading and clamp to the map
	always_comb begin
		nx = $signed({2'b00, agent_x_q})
			+ SW'(sast_pkg::unit_step(h_new_q + HB'(sast_pkg::QSTEPS)));
		ny = $signed({2'b00, agent_y_q}) + SW'(sast_pkg::unit_step(h_new_q));
		move_wall = 1'b0;
		if (nx[SW-1]) begin
			move_x = '0;
			move_wall = 1'b1;
		end else if (nx >= sast_pkg::X_TOP) begin
			move_x = sast_pkg::X_LAST;
			move_wall = 1'b1;
		end else begin
			move_x = nx[PW-1:0];
		end
		if (ny[SW-1]) begin
			move_y = '0;
			move_wall = 1'b1;
		end else if (ny >= sast_pkg::Y_TOP) begin
			move_y = sast_pkg::Y_LAST;
			move_wall = 1'b1;
		end else begin
			move_y = ny[PW-1:0];
		end
		move_addr = AW'(32'(move_y[FB +: sast_pkg::YCELL_W]) * sast_pkg::MAP_WIDTH
			+ 32'(move_x[FB +: sast_pkg::XCELL_W]));
	end

	always_comb begin
		pixel_ok = (32'(pixel_x_q) < sast_pkg::MAP_WIDTH) && (32'(pixel_y_q) < sast_pkg::MAP_HEIGHT);
		pixel_addr = AW'(32'(pixel_y_q) * sast_pkg::MAP_WIDTH + 32'(pixel_x_q));
	end

	// map port arbitration: clear, pixel write, trail mark, sensor read
	always_comb begin
		ram_addr  = sense_addr;
		ram_we    = 1'b0;
		ram_wdata = sast_pkg::TRAIL_FULL;
		if (clearing_q) begin
			ram_addr  = clr_addr_q;
			ram_we    = 1'b1;
			ram_wdata = sast_pkg::TRAIL_ZERO;
		end else if (ctl.wr_pixel) begin
			ram_addr  = pixel_addr;
			ram_we    = go && pixel_ok;
			ram_wdata = pixel_value_q;
		end else if (ctl.move) begin
			ram_addr  = move_addr;
			ram_we    = go;
		end
	end

	sast_ram #(
		.WIDTH(8),
		.DEPTH(sast_pkg::MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// sample capture and turn decision
	always_ff @(posedge clk) begin
		ok_s1 <= ctl.sense && sense_ok;
		case (ctl.cap)
			sast_pkg::CAP_C: centre_q <= ok_s1 ? ram_rdata : sast_pkg::TRAIL_ZERO;
			sast_pkg::CAP_L: left_q   <= ok_s1 ? ram_rdata : sast_pkg::TRAIL_ZERO;
			default: ;
		endcase
		if (ctl.decide) begin
			if (centre_q >= left_q && centre_q >= right_val) begin
				kind_q  <= sast_pkg::KIND_FORWARD;
				h_new_q <= heading_q;
			end else if (right_val >= left_q) begin
				kind_q  <= sast_pkg::KIND_RIGHT;
				h_new_q <= heading_q + HB'(turn_angle_q);
			end else begin
				kind_q  <= sast_pkg::KIND_LEFT;
				h_new_q <= heading_q - HB'(turn_angle_q);
			end
		end
	end

	always_comb begin
		agent_x_nxt = agent_x_q;
		agent_y_nxt = agent_y_q;
		if (ctl.place) begin
			agent_x_nxt = place_x_q;
			agent_y_nxt = place_y_q;
		end else if (ctl.move) begin
			agent_x_nxt = move_x;
			agent_y_nxt = move_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agent_x_q <= '0;
			agent_y_q <= '0;
			heading_q <= '0;
		end else if (go) begin
			agent_x_q <= agent_x_nxt;
			agent_y_q <= agent_y_nxt;
			if (ctl.place) begin
				heading_q <= place_heading_q;
			end else if (ctl.move) begin
				heading_q <= move_wall ? random_heading_q : h_new_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit && go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && go) begin
			agent_column_q <= agent_x_nxt[FB +: sast_pkg::OUT_W];
			agent_row_q    <= agent_y_nxt[FB +: sast_pkg::OUT_W];
			move_kind_q    <= ctl.move ? kind_q : sast_pkg::KIND_NONE;
			hit_wall_q     <= ctl.move && move_wall;
		end
	end

	assign out_valid    = out_valid_q;
	assign agent_column = agent_column_q;
	assign agent_row    = agent_row_q;
	assign move_kind    = move_kind_q;
	assign hit_wall     = hit_wall_q;

	// ---------------- assertions ----------------
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pc_q != sast_pkg::PC_IDLE)
		else $error("sequencer stayed idle after accepting a request");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && go) |=> out_valid)
		else $error("result row did not fill the output register");

	a_clear_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (pc_q == sast_pkg::PC_IDLE && !in_ready))
		else $error("request handled during map clear");

	a_wall_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit_wall) |-> move_kind != sast_pkg::KIND_NONE)
		else $error("wall flag on a result that made no step");

endmodule

// ===== rtl/sast_ram.sv =====
// ----------------------------------------------------------------------------
// sast_ram - generic single-port RAM
// One read or write per cycle, read data registered, no reset on contents.
// ----------------------------------------------------------------------------
module sast_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== tb/slime_agent_sense_turn_step_test.sv =====
// ----------------------------------------------------------------------------
// slime_agent_sense_turn_step_test - self-checking bench for the slime agent step
// Drives write, place, step and unused requests with random idle gaps on both
// channels, predicts every result from a local copy of the map and the agent,
// and checks each result field by field across several angle settings.
// ----------------------------------------------------------------------------
module slime_agent_sense_turn_step_test;
	import sast_pkg::*;

	// the package names the three live actions; code 3 is the unused one
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT = 600000; // clear pass plus ~1550 requests, many times over
	localparam int HOLD_START  = 400;    // requests taken before the long output stall
	localparam int HOLD_CYCLES = 500;
	localparam int PHASES      = 6;
	localparam int FIRST_WALKS = 230;    // random requests after the directed list
	localparam int PHASE_WALKS = 260;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  px;
		logic [7:0]  py;
		logic [7:0]  pval;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [9:0]  sh;
		logic [9:0]  rh;
	} agent_req_t;

	localparam int REQ_W = $bits(agent_req_t);

	typedef struct packed {
		logic [7:0] column;
		logic [7:0] row;
		logic [1:0] kind;
		logic       wall;
	} agent_res_t;

	// ------------------------------------------------------------------------
	// DUT signals, inputs all known from time zero
	// ------------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           action = '0;
	logic [7:0]           pixel_x = '0;
	logic [7:0]           pixel_y = '0;
	logic [7:0]           pixel_value = '0;
	logic [15:0]          place_x = '0;
	logic [15:0]          place_y = '0;
	logic [9:0]           place_heading = '0;
	logic [9:0]           random_heading = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           agent_column;
	logic [7:0]           agent_row;
	logic [1:0]           move_kind;
	logic                 hit_wall;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SENSOR_ANGLE;
	logic [ANGLE_W-1:0]   cfg_data = '0;

	slime_agent_sense_turn_step dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Local model of the block: trail map, agent and angle registers
	// ------------------------------------------------------------------------
	logic [7:0]   trail [MAP_DEPTH];
	logic [15:0]  walk_x = '0;
	logic [15:0]  walk_y = '0;
	logic [9:0]   walk_head = '0;
	logic [8:0]   sense_ang = ANGLE_RESET;
	logic [8:0]   turn_ang = ANGLE_RESET;

	agent_req_t   pending_req[$];   // requests not yet offered
	agent_res_t   expected_pos[$];  // predicted results, oldest first
	agent_req_t   cur_req;

	int n_accepted = 0;
	int n_results = 0;
	int n_steps = 0;
	int n_right = 0;
	int n_left = 0;
	int n_walls = 0;
	int mismatches = 0;
	int cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	logic burst_mode [2] = '{1'b0, 1'b0};  // per side: 0 sender, 1 receiver
	logic hold_long = 1'b0;
	int   hold_left = HOLD_CYCLES;

	// One-pixel displacement along sin(h), signed, FRAC_BITS fraction.
	// Quarter-turn polynomial in Q14, then round half up to the pixel scale.
	function automatic int sine_px(logic [HEADING_BITS-1:0] h);
		longint t, t2, inner, mid, s;
		int r;
		r = int'(h[QBITS-1:0]);
		if (h[QBITS]) begin
			r = QSTEPS - r;
		end
		t = longint'(r) << (14 - QBITS);
		t2 = (t * t) >> 14;
		inner = SIN_B - ((t2 * SIN_C) >> 14);
		mid = SIN_A - ((t2 * inner) >> 14);
		s = (((t * mid) >> 15) << FRAC_BITS) + 8192;
		return h[HEADING_BITS-1] ? -int'(s >> 14) : int'(s >> 14);
	endfunction

	// Trail one pixel ahead along heading h; off-map (floor) reads as zero.
	function automatic logic [7:0] trail_ahead(logic [HEADING_BITS-1:0] h);
		int ax, ay;
		ax = int'(walk_x) + sine_px(h + HEADING_BITS'(QSTEPS));
		ay = int'(walk_y) + sine_px(h);
		if (ax < 0 || ay < 0) begin
			return 8'h00;
		end
		if ((ax >> FRAC_BITS) >= MAP_WIDTH || (ay >> FRAC_BITS) >= MAP_HEIGHT) begin
			return 8'h00;
		end
		return trail[(ay >> FRAC_BITS) * MAP_WIDTH + (ax >> FRAC_BITS)];
	endfunction

	// Apply one accepted request to the local model, queue its result.
	task automatic predict_request(input agent_req_t rq);
		agent_res_t res;
		logic [7:0] fwd, lft, rgt;
		logic [9:0] h, hl, hr;
		int nx, ny;
		logic wall;
		res.kind = KIND_NONE;
		wall = 1'b0;
		case (rq.action)
			ACT_WRITE: begin
				trail[{rq.py, rq.px}] = rq.pval;
			end
			ACT_PLACE: begin
				walk_x = rq.sx;
				walk_y = rq.sy;
				walk_head = rq.sh;
			end
			ACT_STEP: begin
				h = walk_head;
				hl = h - 10'(sense_ang);
				hr = h + 10'(sense_ang);
				fwd = trail_ahead(h);
				lft = trail_ahead(hl);
				rgt = trail_ahead(hr);
				// straight on unless a side beats the centre; right wins a tie
				if (fwd >= lft && fwd >= rgt) begin
					res.kind = KIND_FORWARD;
				end else if (rgt >= lft) begin
					res.kind = KIND_RIGHT;
					h = h + 10'(turn_ang);
					n_right++;
				end else begin
					res.kind = KIND_LEFT;
					h = h - 10'(turn_ang);
					n_left++;
				end
				nx = int'(walk_x) + sine_px(h + HEADING_BITS'(QSTEPS));
				ny = int'(walk_y) + sine_px(h);
				// clamp each axis; the top edge lands on the last pixel, zero fraction
				if (nx < 0) begin
					nx = 0;
					wall = 1'b1;
				end else if (nx >= (MAP_WIDTH << FRAC_BITS)) begin
					nx = (MAP_WIDTH - 1) << FRAC_BITS;
					wall = 1'b1;
				end
				if (ny < 0) begin
					ny = 0;
					wall = 1'b1;
				end else if (ny >= (MAP_HEIGHT << FRAC_BITS)) begin
					ny = (MAP_HEIGHT - 1) << FRAC_BITS;
					wall = 1'b1;
				end
				walk_x = 16'(nx);
				walk_y = 16'(ny);
				walk_head = wall ? rq.rh : h;
				trail[{walk_y[15:8], walk_x[15:8]}] = TRAIL_FULL;
				n_steps++;
				if (wall) begin
					n_walls++;
				end
			end
			default: begin
			end
		endcase
		res.column = walk_x[15:8];
		res.row = walk_y[15:8];
		res.wall = wall;
		expected_pos.push_back(res);
	endtask

	// Idle cycles before the next item on one side; bursts with no idling
	// come and go so that back-to-back traffic is seen too.
	function automatic int idle_cycles(input int side);
		if ($urandom_range(0, 47) == 0) begin
			burst_mode[side] = !burst_mode[side];
		end
		return burst_mode[side] ? 0 : int'($urandom_range(0, 19));
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offers pending requests, predicts each one as it is taken
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_request(cur_req);
				n_accepted <= n_accepted + 1;
				send_gap = idle_cycles(0);
			end
			// a held request stays put; otherwise load the next one or idle
			if (!in_valid || in_ready) begin
				if (send_gap == 0 && pending_req.size() > 0) begin
					cur_req = pending_req.pop_front();
					in_valid <= 1'b1;
					action <= cur_req.action;
					pixel_x <= cur_req.px;
					pixel_y <= cur_req.py;
					pixel_value <= cur_req.pval;
					place_x <= cur_req.sx;
					place_y <= cur_req.sy;
					place_heading <= cur_req.sh;
					random_heading <= cur_req.rh;
				end else begin
					in_valid <= 1'b0;
					if (send_gap > 0) begin
						send_gap--;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: takes results with random stalls, checks against the oldest
	// prediction
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		agent_res_t got, want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{column: agent_column, row: agent_row, kind: move_kind,
					wall: hit_wall};
				n_results <= n_results + 1;
				if (expected_pos.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("[%0d] result with no request pending: col %0d row %0d kind %0d wall %0d",
							cycles, got.column, got.row, got.kind, got.wall);
					end
				end else begin
					want = expected_pos.pop_front();
					if (got.column !== want.column || got.row !== want.row ||
							got.kind !== want.kind || got.wall !== want.wall) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("[%0d] mismatch: expected col %0d row %0d kind %0d wall %0d, got col %0d row %0d kind %0d wall %0d",
								cycles, want.column, want.row, want.kind, want.wall,
								got.column, got.row, got.kind, got.wall);
						end
					end
				end
				recv_gap = idle_cycles(1);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !hold_long;
			end
		end
	end

	// Long output stall, once: the sender keeps offering, so the result
	// register and the next finished result back up and in_ready drops.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_long <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else if (hold_long) begin
			if (hold_left == 1) begin
				hold_long <= 1'b0;
			end
			hold_left <= hold_left - 1;
		end else if (hold_left == HOLD_CYCLES && n_accepted >= HOLD_START) begin
			hold_long <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// every field random, so unused fields toggle too; the caller sets the rest
	function automatic agent_req_t random_req(logic [1:0] act);
		agent_req_t rq;
		rq = REQ_W'({$urandom, $urandom, $urandom});
		rq.action = act;
		return rq;
	endfunction

	task automatic queue_write(input logic [7:0] x, input logic [7:0] y, input logic [7:0] v);
		agent_req_t rq;
		rq = random_req(ACT_WRITE);
		rq.px = x;
		rq.py = y;
		rq.pval = v;
		pending_req.push_back(rq);
	endtask

	task automatic queue_place(input logic [15:0] x, input logic [15:0] y, input logic [9:0] h);
		agent_req_t rq;
		rq = random_req(ACT_PLACE);
		rq.sx = x;
		rq.sy = y;
		rq.sh = h;
		pending_req.push_back(rq);
	endtask

	task automatic queue_step(input logic [9:0] rh);
		agent_req_t rq;
		rq = random_req(ACT_STEP);
		rq.rh = rh;
		pending_req.push_back(rq);
	endtask

	// Random walks: place the agent (often on an edge), paint trail near it,
	// then a run of steps. A little noise: stray writes and unused actions.
	task automatic load_walks(input int count);
		agent_req_t rq;
		int made, bx, by, run;
		logic [15:0] sx, sy;
		logic [9:0] h;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 19) == 0) begin
				rq = random_req($urandom_range(0, 1) ? ACT_UNUSED : ACT_WRITE);
				pending_req.push_back(rq);
				if (rq.action == ACT_WRITE) begin
					made++;
				end
			end else begin
				sx = 16'($urandom);
				sy = 16'($urandom);
				case ($urandom_range(0, 2))
					0: sx[15:8] = 8'($urandom_range(0, 1));
					1: sx[15:8] = 8'($urandom_range(254, 255));
					default: begin
					end
				endcase
				case ($urandom_range(0, 2))
					0: sy[15:8] = 8'($urandom_range(0, 1));
					1: sy[15:8] = 8'($urandom_range(254, 255));
					default: begin
					end
				endcase
				h = 10'($urandom);
				if ($urandom_range(0, 3) == 0) begin
					h[7:0] = 8'h00;   // axis-aligned heading, straight into a wall
				end
				queue_place(sx, sy, h);
				made++;
				bx = int'(sx[15:8]);
				by = int'(sy[15:8]);
				repeat ($urandom_range(0, 4)) begin
					queue_write(8'(bx + int'($urandom_range(0, 6)) - 3),
						8'(by + int'($urandom_range(0, 6)) - 3), 8'($urandom));
					made++;
				end
				run = int'($urandom_range(1, 12));
				repeat (run) begin
					if ($urandom_range(0, 3) == 0) begin
						queue_write(8'(bx + int'($urandom_range(0, 8)) - 4),
							8'(by + int'($urandom_range(0, 8)) - 4), 8'($urandom));
						made++;
					end
					queue_step(10'($urandom));
					made++;
				end
			end
		end
	endtask

	// Wait until every request is taken and every result checked, then let
	// the sequencer fall back to idle.
	task automatic settle();
		while (pending_req.size() != 0 || in_valid || expected_pos.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// Angle registers are only written while nothing is in flight.
	task automatic write_angles(input logic [8:0] s, input logic [8:0] t);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SENSOR_ANGLE;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= REG_TURN_ANGLE;
		cfg_data <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		sense_ang = s;
		turn_ang = t;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		agent_req_t rq;
		for (int i = 0; i < MAP_DEPTH; i++) begin
			trail[i] = 8'h00;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, reset angles (128 / 128). The block clears its map
		// first, so these wait on in_ready for the whole clear pass.

		// unused action with every field high: no change, no step
		rq = '1;
		rq.action = ACT_UNUSED;
		pending_req.push_back(rq);
		queue_write(8'd0, 8'd0, 8'd255);
		queue_write(8'd255, 8'd255, 8'd0);

		// clamp on the left, right, top and bottom edges; sensors facing out read zero
		queue_place(16'h0000, 16'h8000, 10'd512);
		queue_step(10'h3FF);
		queue_place(16'hFFFF, 16'h8000, 10'd0);
		queue_step(10'h000);
		queue_place(16'h8000, 16'hFF80, 10'd256);
		queue_step(10'h2AA);
		queue_place(16'h8000, 16'h0040, 10'd768);
		queue_step(10'h155);

		// agent at pixel (64,64) heading +x: centre (65,64), left (65,63),
		// right (65,65). Right stronger, then left stronger, then a side tie.
		queue_write(8'd65, 8'd65, 8'd200);
		queue_write(8'd65, 8'd63, 8'd100);
		queue_write(8'd65, 8'd64, 8'd50);
		queue_place(16'h4080, 16'h4080, 10'd0);
		queue_step(10'($urandom));
		queue_write(8'd65, 8'd65, 8'd10);
		queue_write(8'd65, 8'd63, 8'd250);
		queue_place(16'h4080, 16'h4080, 10'd0);
		queue_step(10'($urandom));
		queue_write(8'd65, 8'd63, 8'd77);
		queue_write(8'd65, 8'd65, 8'd77);
		queue_place(16'h4080, 16'h4080, 10'd0);
		queue_step(10'($urandom));

		load_walks(FIRST_WALKS);
		settle();

		// remaining phases: each angle register at both extremes, then random
		for (int p = 1; p < PHASES; p++) begin
			case (p)
				1: write_angles(9'd0, 9'd511);
				2: write_angles(9'd511, 9'd0);
				default: write_angles(9'($urandom), 9'($urandom));
			endcase
			load_walks(PHASE_WALKS);
			settle();
		end

		repeat (20) @(posedge clk);
		$display("%0d requests, %0d results checked: %0d steps, %0d right and %0d left turns, %0d wall hits",
			n_accepted, n_results, n_steps, n_right, n_left, n_walls);
		$display("%0d angle settings, one %0d-cycle output stall, %0d mismatches",
			PHASES, HOLD_CYCLES, mismatches);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
